@@ sv/sim_pkg.sv @@
// shared constants, payload type and round functions for the simon 32/64 encryptor
package sim_pkg;

    localparam int SIM_ROUNDS = 32;
    localparam int SIM_WORD_W = 16;
    localparam int SIM_BLK_W  = 32;
    localparam int SIM_KEY_W  = 64;
    localparam int SIM_Z_PERIOD = 31;

    localparam logic [63:0] SIM_Z0       = 64'h19C3_522F_B386_A45F;
    localparam logic [15:0] SIM_KS_CONST = 16'hfffc;

    // block and evolving key travelling together down the pipeline
    typedef struct packed {
        logic [SIM_BLK_W-1:0] blk;
        logic [SIM_KEY_W-1:0] key;
    } t_sim_data;

    // one feistel round: new left = right ^ f(left) ^ round key
    function automatic logic [SIM_BLK_W-1:0] sim_round(
        input logic [SIM_BLK_W-1:0]  blk,
        input logic [SIM_WORD_W-1:0] rk
    );
        logic [15:0] l;
        logic [15:0] r;
        logic [15:0] f;
        l = blk[31:16];
        r = blk[15:0];
        f = ({l[14:0], l[15]} & {l[7:0], l[15:8]}) ^ {l[13:0], l[15:14]};
        return {r ^ f ^ rk, l};
    endfunction

    // one key schedule step with the z0 bit of this round
    function automatic logic [SIM_KEY_W-1:0] sim_next_key(
        input logic [SIM_KEY_W-1:0] k,
        input logic                 zbit
    );
        logic [15:0] k3;
        logic [15:0] t;
        logic [15:0] nk;
        k3 = k[63:48];
        t  = {k3[2:0], k3[15:3]} ^ k[31:16];
        nk = k[15:0] ^ t ^ {t[0], t[15:1]} ^ {15'd0, zbit} ^ SIM_KS_CONST;
        return {nk, k[63:16]};
    endfunction

endpackage

@@ sv/sim_stage.sv @@
// one pipeline stage: a cipher round, a key schedule step and a skid-free handover
module sim_stage #(
    parameter int ROUND_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sim_pkg::t_sim_data  i_data,
    output logic                o_ready,
    output logic                o_valid,
    output sim_pkg::t_sim_data  o_data,
    input  logic                i_ready_next
);
    import sim_pkg::*;

    localparam logic ZBIT = SIM_Z0[ROUND_IDX % SIM_Z_PERIOD];

    logic       r_valid;
    t_sim_data  r_data;
    t_sim_data  n_data;

    // stage may load when empty or when its content moves on
    assign o_ready = !r_valid || i_ready_next;

    // round and key update
    always_comb begin
        n_data.blk = sim_round(i_data.blk, i_data.key[15:0]);
        n_data.key = sim_next_key(i_data.key, ZBIT);
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sv/simon_32_64_encrypt.sv @@
// top level of the pipelined simon 32/64 block encryptor
// Simon 32/64 encryptor, one round per pipeline stage: a request is taken every cycle while
// o_stall is low, and its ciphertext leaves through the ROUNDS stage registers (32 by
// default), each holding one feistel round and one key schedule step. The
// 64-bit key is loaded through i_cfg_we / i_cfg_data and travels with each block, so it
// must only be rewritten while no request is in flight. Every stage hands over as soon as
// the next one has room, so bubbles close up and new requests are taken while a finished
// result waits under i_stall.
module simon_32_64_encrypt #(
    parameter int ROUNDS = sim_pkg::SIM_ROUNDS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sim_pkg::SIM_KEY_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sim_pkg::SIM_BLK_W-1:0] i_plaintext,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sim_pkg::SIM_BLK_W-1:0] o_ciphertext
);
    import sim_pkg::*;

    logic [SIM_KEY_W-1:0] r_cipher_key;

    logic      w_valid [ROUNDS+1];
    logic      w_ready [ROUNDS+1];
    t_sim_data w_data  [ROUNDS+1];

    // key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (i_cfg_we) begin
            r_cipher_key <= i_cfg_data;
        end
    end

    // pipeline entry
    assign w_valid[0]      = i_valid;
    assign w_data[0].blk   = i_plaintext;
    assign w_data[0].key   = r_cipher_key;
    assign o_stall         = !w_ready[0];

    // round stages
    for (genvar g = 0; g < ROUNDS; g++) begin : g_stage
        sim_stage #(
            .ROUND_IDX (g)
        ) u_stage (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (w_valid[g]),
            .i_data       (w_data[g]),
            .o_ready      (w_ready[g]),
            .o_valid      (w_valid[g+1]),
            .o_data       (w_data[g+1]),
            .i_ready_next (w_ready[g+1])
        );
    end

    // pipeline exit
    assign w_ready[ROUNDS] = !i_stall;
    assign o_valid         = w_valid[ROUNDS];
    assign o_ciphertext    = w_data[ROUNDS].blk;

    // an empty output stage means the whole chain can take a request
    a_free_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled although output stage is empty");

    // a stalled input implies the first stage is occupied
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_valid[1])
        else $error("input stalled with first stage empty");

    // an accepted request lands in the first stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_valid[1])
        else $error("accepted request lost at first stage");

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule

@@ test/tb_simon_32_64_encrypt.sv @@
// self-checking testbench for the pipelined simon 32/64 block encryptor
module tb_simon_32_64_encrypt;

    import sim_pkg::*;

    localparam int ROUND_COUNT    = SIM_ROUNDS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PERCENT   = 17;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_AT_RESULT = 300;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BLOCKS   = 240;

    // one pending request: a key load or a plaintext block
    typedef struct {
        bit                   key_load;
        logic [SIM_KEY_W-1:0] data;
    } t_job;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [SIM_KEY_W-1:0] i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [SIM_BLK_W-1:0] i_plaintext;
    logic                 o_valid;
    logic                 i_stall;
    logic [SIM_BLK_W-1:0] o_ciphertext;

    t_job                 job_q[$];
    logic [SIM_BLK_W-1:0] expected_ciphertext_q[$];
    logic [SIM_KEY_W-1:0] model_key;
    logic [SIM_BLK_W-1:0] oldest_ct;
    bit                   block_taken;
    bit                   hold_done;
    int                   hold_left;
    int                   blocks_in;
    int                   blocks_out;
    int                   quiet_cycles;
    int                   fail_count;
    wire                  calm = (blocks_in >= 700) && (blocks_in < 1000);

    simon_32_64_encrypt dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_plaintext  (i_plaintext),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ciphertext (o_ciphertext)
    );

    // 16-bit rotations used by the predictor
    function automatic logic [15:0] rotl16(input logic [15:0] v, input int s);
        return (v << s) | (v >> (16 - s));
    endfunction

    function automatic logic [15:0] rotr16(input logic [15:0] v, input int s);
        return (v >> s) | (v << (16 - s));
    endfunction

    // full encryption of one block, expanding the key round by round
    function automatic logic [SIM_BLK_W-1:0] encrypt_block(
        input logic [SIM_BLK_W-1:0] plain,
        input logic [SIM_KEY_W-1:0] key
    );
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] mix;
        logic [15:0] tmp;
        logic [15:0] fresh;
        logic [63:0] ks;
        left  = plain[31:16];
        right = plain[15:0];
        ks    = key;
        for (int rnd = 0; rnd < ROUND_COUNT; rnd++) begin
            mix   = (rotl16(left, 1) & rotl16(left, 8)) ^ rotl16(left, 2);
            tmp   = right ^ mix ^ ks[15:0];
            right = left;
            left  = tmp;
            tmp   = rotr16(ks[63:48], 3) ^ ks[31:16];
            fresh = ks[15:0] ^ tmp ^ rotr16(tmp, 1) ^ SIM_KS_CONST
                  ^ {15'd0, SIM_Z0[rnd % SIM_Z_PERIOD]};
            ks    = {fresh, ks[63:16]};
        end
        return {left, right};
    endfunction

    task automatic add_key(input logic [SIM_KEY_W-1:0] k);
        t_job j;
        j.key_load = 1'b1;
        j.data     = k;
        job_q.push_back(j);
    endtask

    task automatic add_block(input logic [SIM_BLK_W-1:0] p);
        t_job j;
        j.key_load = 1'b0;
        j.data     = {32'd0, p};
        job_q.push_back(j);
    endtask

    // mostly random blocks, with the odd extreme, single-bit or single-zero pattern
    function automatic logic [SIM_BLK_W-1:0] random_block();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85) return $urandom;
        if (pick < 89) return 32'h0000_0000;
        if (pick < 93) return 32'hffff_ffff;
        if (pick < 97) return 32'h1 << $urandom_range(31);
        return ~(32'h1 << $urandom_range(31));
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stimulus, reset and end of run
    initial begin
        logic [SIM_BLK_W-1:0] corner[8];
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_plaintext = '0;
        i_stall     = 1'b0;
        model_key   = '0;
        corner = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
                   32'hffff_0000, 32'h0000_ffff, 32'haaaa_5555, 32'h5555_aaaa};

        // directed: extreme keys and blocks, then the published test vector
        add_key(64'h0);
        foreach (corner[i]) add_block(corner[i]);
        add_key(64'hffff_ffff_ffff_ffff);
        foreach (corner[i]) add_block(corner[i]);
        add_key(64'h1918_1110_0908_0100);
        add_block(32'h6565_6877);
        add_block(32'h0000_0000);
        add_block(32'hffff_ffff);
        add_block(32'h8000_0001);

        // random phases, each under a fresh key
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 2) add_key(64'hffff_0000_ffff_0000);
            else add_key({$urandom, $urandom});
            for (int n = 0; n < PHASE_BLOCKS; n++) add_block(random_block());
        end
        add_key(64'h0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (job_q.size() != 0 || i_valid || i_cfg_we || expected_ciphertext_q.size() != 0)
            @(posedge i_clk);
        repeat (ROUND_COUNT + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_simon_32_64_encrypt: PASS");
        end else begin
            $display("tb_simon_32_64_encrypt: FAIL");
        end
        $finish;
    end

    // request driver: holds a stalled block, loads keys only when the pipe is empty
    always @(negedge i_clk) begin : drive
        logic                 nxt_valid;
        logic                 nxt_we;
        logic [SIM_KEY_W-1:0] nxt_cfg;
        logic [SIM_BLK_W-1:0] nxt_pt;
        t_job                 j;
        if (i_rst_n) begin
            nxt_valid = i_valid && !block_taken;
            nxt_we    = 1'b0;
            nxt_cfg   = i_cfg_data;
            nxt_pt    = i_plaintext;
            if (!nxt_valid && job_q.size() != 0) begin
                if (job_q[0].key_load) begin
                    if (expected_ciphertext_q.size() == 0) begin
                        j         = job_q.pop_front();
                        nxt_we    = 1'b1;
                        nxt_cfg   = j.data;
                        model_key = j.data;
                    end
                end else if (calm || $urandom_range(99) >= IDLE_PERCENT) begin
                    j         = job_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_pt    = j.data[SIM_BLK_W-1:0];
                end
            end
            i_valid     <= nxt_valid;
            i_cfg_we    <= nxt_we;
            i_cfg_data  <= nxt_cfg;
            i_plaintext <= nxt_pt;
        end
    end

    // result receiver: random stalls outside the calm window plus one long hold-off to fill the pipe
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else if (!hold_done && blocks_out >= HOLD_AT_RESULT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // monitor: predicts on accepted requests, checks accepted results in order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            block_taken  = 1'b0;
            quiet_cycles = 0;
        end else begin
            block_taken = i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                if (expected_ciphertext_q.size() == 0) begin
                    $error("ciphertext: none expected, actual %h", o_ciphertext);
                    fail_count++;
                end else begin
                    oldest_ct = expected_ciphertext_q.pop_front();
                    if (o_ciphertext !== oldest_ct) begin
                        $error("ciphertext: expected %h, actual %h", oldest_ct, o_ciphertext);
                        fail_count++;
                    end
                end
                blocks_out++;
            end
            if (block_taken) begin
                expected_ciphertext_q.push_back(encrypt_block(i_plaintext, model_key));
                blocks_in++;
            end
            if (block_taken || (o_valid && !i_stall) || i_cfg_we) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    // watchdog on cycles with no progress
    always @(negedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_simon_32_64_encrypt: FAIL");
            $finish;
        end
    end

endmodule
